### hdl/abnal_pkg.sv
// ----------------------------------------------------------------------------
// abnal_pkg
// shared types, constants and helpers of the annex-b to length-prefixed converter
// ----------------------------------------------------------------------------
`default_nettype none

package abnal_pkg;

	// frame addressing
	localparam int FRAME_ADDR_BITS = 24;
	localparam int CNT_W           = FRAME_ADDR_BITS;
	localparam int POS_W           = FRAME_ADDR_BITS + 1;
	localparam int FIELD_W         = 25;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration port
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam logic [2:0] MAX_ZERO_RUN_RESET = 3'd3;

	// result bundle queue
	localparam int MAX_RES     = 4;
	localparam int RES_IDX_W   = $clog2(MAX_RES);
	localparam int RES_CNT_W   = RES_IDX_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// stream bytes and sizes
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [7:0] BYTE_EPB  = 8'h03;
	localparam int SLOT_BYTES      = 4;
	localparam int EPB_ZEROS       = 2;
	localparam int MIN_START_ZEROS = 2;

	typedef enum logic [2:0] {
		KIND_BYTE  = 3'd0,
		KIND_FILL  = 3'd1,
		KIND_PATCH = 3'd2,
		KIND_DONE  = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REMOVE_EPB          = 2'd0,
		REG_MAX_ZERO_RUN        = 2'd1,
		REG_SIZE_AT_LEAST_INPUT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] following_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] out_address;
		logic [FIELD_W-1:0] out_value;
		logic               last_of_run;
	} result_t;

	// all results caused by one input byte, compacted to the low slots
	typedef struct packed {
		logic [RES_CNT_W-1:0]       cnt;
		result_t [MAX_RES-1:0]      res;
	} bundle_t;

	typedef struct packed {
		logic       remove_epb;
		logic [2:0] max_zero_run;
		logic       size_at_least_input;
	} cfg_t;

	function automatic logic [FIELD_W-1:0] to_field(input logic [63:0] v);
		return v[FIELD_W-1:0];
	endfunction

	function automatic result_t mk_result(input kind_t k, input logic [63:0] a,
			input logic [63:0] v);
		result_t r;
		r.kind        = k;
		r.out_address = to_field(a);
		r.out_value   = to_field(v);
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/abnal_front.sv
// ----------------------------------------------------------------------------
// abnal_front
// per-byte classifier: zero runs, start codes, epb drop, frame end flush
// ----------------------------------------------------------------------------
`default_nettype none

module abnal_front import abnal_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 accept,
	input  wire in_item_t             item,
	output logic                      q_wr,
	output bundle_t                   q_data
);

	cfg_t             cfg_q;
	logic [CNT_W-1:0] zc_q, zc_d, icnt_q, icnt_d;
	logic [POS_W-1:0] pos_q, pos_d, rl_q, rl_d, slot_q, slot_d, zc_ext, size;
	logic             open_q, open_d, failed_q, failed_d, clear, err;
	logic [RES_CNT_W-1:0] n;
	result_t [MAX_RES-1:0] res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remove_epb          <= 1'b0;
			cfg_q.max_zero_run        <= MAX_ZERO_RUN_RESET;
			cfg_q.size_at_least_input <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REMOVE_EPB:          cfg_q.remove_epb          <= cfg_data[0];
				REG_MAX_ZERO_RUN:        cfg_q.max_zero_run        <= cfg_data[2:0];
				REG_SIZE_AT_LEAST_INPUT: cfg_q.size_at_least_input <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		zc_d     = zc_q;
		pos_d    = pos_q;
		rl_d     = rl_q;
		slot_d   = slot_q;
		open_d   = open_q;
		icnt_d   = icnt_q;
		failed_d = failed_q;
		clear    = 1'b0;
		err      = 1'b0;
		n        = '0;
		res      = '0;
		zc_ext   = POS_W'(zc_q);
		size     = '0;
		if (failed_q) begin
			// rest of a failed frame is dropped
			clear = item.is_last;
		end else begin
			if (icnt_q != CNT_MAX) begin
				icnt_d = icnt_q + CNT_W'(1);
			end
			priority if (item.data_byte == BYTE_ZERO) begin
				if (zc_q != CNT_MAX) begin
					zc_d = zc_q + CNT_W'(1);
				end
			end else if (zc_q > CNT_W'(cfg_q.max_zero_run)) begin
				res[n[RES_IDX_W-1:0]] = mk_result(KIND_ERROR, 64'(pos_q), 64'(zc_q));
				n   = n + RES_CNT_W'(1);
				err = 1'b1;
				if (item.is_last) begin
					clear = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end else if (item.data_byte == BYTE_ONE && zc_q >= CNT_W'(MIN_START_ZEROS)) begin
				// start code: close the open slot, open a new one
				if (open_q) begin
					res[n[RES_IDX_W-1:0]] = mk_result(KIND_PATCH, 64'(slot_q), 64'(rl_q));
					n = n + RES_CNT_W'(1);
				end
				slot_d = pos_q;
				open_d = 1'b1;
				pos_d  = pos_q + POS_W'(SLOT_BYTES);
				zc_d   = '0;
				rl_d   = '0;
			end else if (cfg_q.remove_epb && item.data_byte == BYTE_EPB
					&& zc_q == CNT_W'(EPB_ZEROS) && !item.is_last
					&& item.following_byte <= BYTE_EPB) begin
				// emulation prevention byte dropped, its two zeros kept
				res[n[RES_IDX_W-1:0]] = mk_result(KIND_FILL, 64'(pos_q), 64'(EPB_ZEROS));
				n     = n + RES_CNT_W'(1);
				pos_d = pos_q + POS_W'(EPB_ZEROS);
				rl_d  = rl_q + POS_W'(EPB_ZEROS);
				zc_d  = '0;
			end else begin
				if (zc_q != '0) begin
					res[n[RES_IDX_W-1:0]] = mk_result(KIND_FILL, 64'(pos_q), 64'(zc_q));
					n = n + RES_CNT_W'(1);
				end
				res[n[RES_IDX_W-1:0]] = mk_result(KIND_BYTE, 64'(pos_q + zc_ext),
					64'(item.data_byte));
				n     = n + RES_CNT_W'(1);
				pos_d = pos_q + zc_ext + POS_W'(1);
				rl_d  = rl_q + zc_ext + POS_W'(1);
				zc_d  = '0;
			end
			if (item.is_last && !err) begin
				// end of frame flush
				if (zc_d != '0) begin
					res[n[RES_IDX_W-1:0]] = mk_result(KIND_FILL, 64'(pos_d), 64'(zc_d));
					n     = n + RES_CNT_W'(1);
					pos_d = pos_d + POS_W'(zc_d);
					rl_d  = rl_d + POS_W'(zc_d);
				end
				if (open_d) begin
					res[n[RES_IDX_W-1:0]] = mk_result(KIND_PATCH, 64'(slot_d), 64'(rl_d));
					n = n + RES_CNT_W'(1);
				end
				size = pos_d;
				if (cfg_q.remove_epb && cfg_q.size_at_least_input
						&& POS_W'(icnt_d) > pos_d) begin
					size = POS_W'(icnt_d);
				end
				res[n[RES_IDX_W-1:0]] = mk_result(KIND_DONE, 64'(pos_d), 64'(size));
				n     = n + RES_CNT_W'(1);
				clear = 1'b1;
			end
		end
		if (clear) begin
			zc_d     = '0;
			pos_d    = '0;
			rl_d     = '0;
			slot_d   = '0;
			open_d   = 1'b0;
			icnt_d   = '0;
			failed_d = 1'b0;
		end
	end

	assign q_wr       = accept && (n != '0);
	assign q_data.cnt = n;
	assign q_data.res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_q     <= '0;
			pos_q    <= '0;
			rl_q     <= '0;
			slot_q   <= '0;
			open_q   <= 1'b0;
			icnt_q   <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			zc_q     <= zc_d;
			pos_q    <= pos_d;
			rl_q     <= rl_d;
			slot_q   <= slot_d;
			open_q   <= open_d;
			icnt_q   <= icnt_d;
			failed_q <= failed_d;
		end
	end

endmodule

`default_nettype wire

### hdl/abnal_queue.sv
// ----------------------------------------------------------------------------
// abnal_queue
// short queue of result bundles between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module abnal_queue import abnal_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire bundle_t wdata,
	input  wire logic    rd,
	output logic         full,
	output logic         empty,
	output bundle_t      rdata
);

	bundle_t [QUEUE_DEPTH-1:0] mem_q;
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/abnal_back.sv
// ----------------------------------------------------------------------------
// abnal_back
// unpacks result bundles one result per cycle into the output register while it is free or popped
// ----------------------------------------------------------------------------
`default_nettype none

module abnal_back import abnal_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_empty,
	input  wire bundle_t q_data,
	output logic         q_rd,
	input  wire logic    pop,
	output logic         empty,
	output result_t      result
);

	result_t              res_q;
	logic                 valid_q;
	logic [RES_IDX_W-1:0] idx_q;
	logic                 load, take, final_res;
	result_t              next_res;

	assign load      = !valid_q || pop;
	assign take      = load && !q_empty;
	assign final_res = (RES_CNT_W'(idx_q) + RES_CNT_W'(1)) == q_data.cnt;
	assign q_rd      = take && final_res;

	always_comb begin
		next_res             = q_data.res[idx_q];
		next_res.last_of_run = final_res;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (take) begin
				idx_q <= final_res ? '0 : idx_q + RES_IDX_W'(1);
			end
		end
	end

	assign empty  = !valid_q;
	assign result = res_q;

endmodule

`default_nettype wire

### hdl/annexb_to_length_prefixed_nal.sv
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal
// annex-b byte stream to length-prefixed nal units, as output-buffer writes
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | transfer when
//  ---------+-----------------------------------------+-------------------
//  input    | push, full, item (in_item_t)            | push && !full
//  result   | empty, pop, result (result_t)           | pop && !empty
//  config   | cfg_write, cfg_index, cfg_data          | cfg_write
//
//  one input byte is taken per cycle while full is low; the front classifies it
//  in that cycle and stores all of its results as one bundle in a 4-deep queue
//  the back sends one result per cycle while its output register is free or popped;
//  a byte with k results has them sent in turn (k is 1 for most bytes, up to 4 at a frame end)
//  first result of a byte passes through the queue, then the output register
//  arst_n clears frame state, queue and output valid flag and loads the register
//  defaults; no clearing pass, the block takes input right after reset
//  a stalled result side fills the queue, then full rises and input stalls
//
`default_nettype none

module annexb_to_length_prefixed_nal import abnal_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input bytes
	input  wire logic                 push,
	output logic                      full,
	input  wire in_item_t             item,
	// results
	output logic                      empty,
	input  wire logic                 pop,
	output result_t                   result
);

	logic    accept;
	logic    q_wr, q_rd, q_empty;
	bundle_t q_wdata, q_rdata;

	// byte transfer on the input side
	assign accept = push && !full;

	// front: zero runs, start codes, epb drop and frame end flush
	abnal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.q_wr      (q_wr),
		.q_data    (q_wdata)
	);

	// bundles waiting for the back; a full queue stalls input
	abnal_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.full   (full),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	// back: one result per cycle into the output register while it is free or popped
	abnal_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

`default_nettype wire

### hdl/abnal_checker.sv
// ----------------------------------------------------------------------------
// abnal_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module abnal_checker import abnal_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    push,
	input wire logic    full,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	// a waiting result holds until transferred
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// frame done closes the results of its byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_DONE) |-> result.last_of_run)
		else $error("frame done not last of its byte");

	// an error is the only result of its byte
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_ERROR) |-> result.last_of_run)
		else $error("error not last of its byte");

	// the queue only fills through an input transfer
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind annexb_to_length_prefixed_nal abnal_checker u_abnal_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

### bench/abnal_checker.sv
// ----------------------------------------------------------------------------
// abnal_tb_checker
// watches the byte, result and register channels of the nal converter,
// predicts the output-buffer writes of every accepted byte and compares them
// in order with the results that the block hands out
// ----------------------------------------------------------------------------

module abnal_tb_checker import abnal_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	input  logic                 full,
	input  in_item_t             item,
	input  logic                 empty,
	input  logic                 pop,
	input  result_t              result,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic       epb_drop;
	logic [2:0] zrun_limit;
	logic       size_floor;

	// per-frame conversion state
	logic [CNT_W-1:0] zero_run;
	logic [CNT_W-1:0] bytes_in;
	logic [POS_W-1:0] wr_pos;
	logic [POS_W-1:0] nal_len;
	logic [POS_W-1:0] slot_addr;
	logic             slot_open;
	logic             frame_dead;

	result_t expected_writes[$];
	int      mismatches;

	function automatic result_t make_write(input kind_t k, input logic [POS_W-1:0] addr,
			input logic [POS_W-1:0] val);
		result_t w;
		w.kind        = k;
		w.out_address = addr;
		w.out_value   = val;
		w.last_of_run = 1'b0;
		return w;
	endfunction

	task automatic clear_frame_state();
		zero_run   = '0;
		bytes_in   = '0;
		wr_pos     = '0;
		nal_len    = '0;
		slot_addr  = '0;
		slot_open  = 1'b0;
		frame_dead = 1'b0;
	endtask

	task automatic predict_nal_writes(input in_item_t it);
		result_t          batch[$];
		result_t          w;
		logic [POS_W-1:0] size;
		// rest of a failed frame is swallowed
		if (frame_dead) begin
			if (it.is_last)
				clear_frame_state();
			return;
		end
		if (bytes_in != CNT_MAX)
			bytes_in = bytes_in + 1'b1;

		if (it.data_byte == BYTE_ZERO) begin
			if (zero_run != CNT_MAX)
				zero_run = zero_run + 1'b1;
		end else if (zero_run > zrun_limit) begin
			w = make_write(KIND_ERROR, wr_pos, POS_W'(zero_run));
			w.last_of_run = 1'b1;
			expected_writes.push_back(w);
			if (it.is_last)
				clear_frame_state();
			else
				frame_dead = 1'b1;
			return;
		end else if (it.data_byte == BYTE_ONE && zero_run >= MIN_START_ZEROS) begin
			// start code: close the open slot, reserve a new one
			if (slot_open)
				batch.push_back(make_write(KIND_PATCH, slot_addr, nal_len));
			slot_addr = wr_pos;
			slot_open = 1'b1;
			wr_pos    = wr_pos + POS_W'(SLOT_BYTES);
			zero_run  = '0;
			nal_len   = '0;
		end else if (epb_drop && it.data_byte == BYTE_EPB && zero_run == EPB_ZEROS &&
				!it.is_last && it.following_byte <= BYTE_EPB) begin
			// emulation prevention byte dropped, its two zeros kept
			batch.push_back(make_write(KIND_FILL, wr_pos, POS_W'(EPB_ZEROS)));
			wr_pos   = wr_pos + POS_W'(EPB_ZEROS);
			nal_len  = nal_len + POS_W'(EPB_ZEROS);
			zero_run = '0;
		end else begin
			if (zero_run != '0)
				batch.push_back(make_write(KIND_FILL, wr_pos, POS_W'(zero_run)));
			batch.push_back(make_write(KIND_BYTE, wr_pos + POS_W'(zero_run),
				POS_W'(it.data_byte)));
			wr_pos   = wr_pos + POS_W'(zero_run) + 1'b1;
			nal_len  = nal_len + POS_W'(zero_run) + 1'b1;
			zero_run = '0;
		end

		if (it.is_last) begin
			if (zero_run != '0) begin
				batch.push_back(make_write(KIND_FILL, wr_pos, POS_W'(zero_run)));
				wr_pos   = wr_pos + POS_W'(zero_run);
				nal_len  = nal_len + POS_W'(zero_run);
				zero_run = '0;
			end
			if (slot_open)
				batch.push_back(make_write(KIND_PATCH, slot_addr, nal_len));
			size = wr_pos;
			if (epb_drop && size_floor && POS_W'(bytes_in) > wr_pos)
				size = POS_W'(bytes_in);
			batch.push_back(make_write(KIND_DONE, wr_pos, size));
			clear_frame_state();
		end

		foreach (batch[i]) begin
			w = batch[i];
			w.last_of_run = (i == batch.size() - 1);
			expected_writes.push_back(w);
		end
	endtask

	task automatic report(input string field, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		mismatches++;
	endtask

	task automatic check_write(input result_t got);
		result_t want;
		if (expected_writes.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual kind %0d addr %0h value %0h",
				$time, got.kind, got.out_address, got.out_value);
			mismatches++;
			return;
		end
		want = expected_writes.pop_front();
		if (got.kind !== want.kind)
			report("kind", FIELD_W'(want.kind), FIELD_W'(got.kind));
		if (got.out_address !== want.out_address)
			report("out_address", want.out_address, got.out_address);
		if (got.out_value !== want.out_value)
			report("out_value", want.out_value, got.out_value);
		if (got.last_of_run !== want.last_of_run)
			report("last_of_run", FIELD_W'(want.last_of_run), FIELD_W'(got.last_of_run));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epb_drop   = 1'b0;
			zrun_limit = MAX_ZERO_RUN_RESET;
			size_floor = 1'b1;
			clear_frame_state();
			expected_writes.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_REMOVE_EPB:          epb_drop   = cfg_data[0];
					REG_MAX_ZERO_RUN:        zrun_limit = cfg_data[2:0];
					REG_SIZE_AT_LEAST_INPUT: size_floor = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full)
				predict_nal_writes(item);
			if (pop && !empty)
				check_write(result);
			fail_count <= mismatches;
			pending    <= expected_writes.size();
		end
	end

endmodule

### bench/tb_annexb_to_length_prefixed_nal.sv
// ----------------------------------------------------------------------------
// tb_annexb_to_length_prefixed_nal
// drives annex-b frames into the converter under several register settings,
// with random idle on both channels and one long result-side hold-off;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------

module tb_annexb_to_length_prefixed_nal import abnal_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 60;
	localparam int PHASES        = 5;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 push      = 1'b0;
	in_item_t             item      = '0;
	logic                 pop       = 1'b0;
	logic                 full;
	logic                 empty;
	result_t              result;
	int                   fail_count;
	int                   pending;

	// sender state: burst_mode turns off input idling, hold_req asks the
	// receiver for its one long hold-off
	bit burst_mode = 1'b0;
	bit hold_req   = 1'b0;
	int items_sent = 0;
	int cycle_cnt  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	annexb_to_length_prefixed_nal u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	abnal_tb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// mostly no gap or a short one, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.data_byte      = 8'($urandom_range(0, 255));
		it.following_byte = 8'($urandom_range(0, 255));
		it.is_last        = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// one byte transfer, then an optional idle gap with junk on the item bus
	task automatic send_byte(input in_item_t it);
		int gap;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		items_sent++;
		if (!burst_mode) begin
			gap = idle_gap();
			if (gap > 0) begin
				push <= 1'b0;
				item <= random_item();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// following byte is the true next byte unless the frame is scrambled;
	// on the final byte it is don't-care, so it gets random content
	task automatic send_frame(input byte_q_t frame, input bit scramble);
		in_item_t it;
		foreach (frame[i]) begin
			it.data_byte = frame[i];
			it.is_last   = (i == frame.size() - 1);
			if (it.is_last || (scramble && $urandom_range(0, 3) == 0))
				it.following_byte = 8'($urandom_range(0, 255));
			else
				it.following_byte = frame[i+1];
			send_byte(it);
		end
	endtask

	// all three registers, one per cycle, while the block is idle
	task automatic write_config(input logic epb, input logic [2:0] limit, input logic floor);
		cfg_write <= 1'b1;
		cfg_index <= REG_REMOVE_EPB;
		cfg_data  <= CFG_W'(epb);
		@(posedge clk);
		cfg_index <= REG_MAX_ZERO_RUN;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_index <= REG_SIZE_AT_LEAST_INPUT;
		cfg_data  <= CFG_W'(floor);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// stop offering bytes and wait until every predicted write came back;
	// the first edge lets the checker's count catch up with the last transfer
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one annex-b frame: start codes of legal or over-long zero runs, payload
	// with emulation prevention sequences, zero runs and low byte values, and
	// an occasional odd ending
	function automatic void gen_frame(output byte_q_t f);
		int  n_nal;
		int  z;
		bit  lead_code;
		f.delete();
		lead_code = ($urandom_range(0, 7) != 0);
		n_nal = $urandom_range(1, 3);
		for (int n = 0; n < n_nal; n++) begin
			if (n > 0 || lead_code) begin
				z = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 3) : $urandom_range(4, 8);
				repeat (z) f.push_back(BYTE_ZERO);
				f.push_back(BYTE_ONE);
			end
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 9))
					0: begin
						// emulation prevention ahead of a low byte
						f.push_back(BYTE_ZERO);
						f.push_back(BYTE_ZERO);
						f.push_back(BYTE_EPB);
						f.push_back(8'($urandom_range(0, 3)));
					end
					1: begin
						// 00 00 03 ahead of any byte
						f.push_back(BYTE_ZERO);
						f.push_back(BYTE_ZERO);
						f.push_back(BYTE_EPB);
						f.push_back(8'($urandom_range(0, 255)));
					end
					2: begin
						repeat ($urandom_range(1, 3)) f.push_back(BYTE_ZERO);
						f.push_back(8'($urandom_range(1, 255)));
					end
					3: f.push_back(8'($urandom_range(0, 3)));
					default: f.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		case ($urandom_range(0, 7))
			0: repeat ($urandom_range(1, 4)) f.push_back(BYTE_ZERO);
			1: begin
				// start code closing the frame
				f.push_back(BYTE_ZERO);
				f.push_back(BYTE_ZERO);
				f.push_back(BYTE_ONE);
			end
			2: begin
				// 03 as the final byte
				f.push_back(BYTE_ZERO);
				f.push_back(BYTE_ZERO);
				f.push_back(BYTE_EPB);
			end
			default: ;
		endcase
	endfunction

	// noise: short frames of mostly low byte values
	function automatic void gen_noise(output byte_q_t f);
		f.delete();
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 1))
				f.push_back(8'($urandom_range(0, 3)));
			else
				f.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		bit hold_served;
		stall_left  = 0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_gap();
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("annexb_to_length_prefixed_nal test failed");
		$finish;
	end

	initial begin
		byte_q_t    frame;
		logic       cfg_epb [PHASES];
		logic [2:0] cfg_lim [PHASES];
		logic       cfg_flr [PHASES];
		int         target;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames: epb dropping on, limit of three zeros
		write_config(1'b1, 3'd3, 1'b1);
		// three-zero start code, dropped 03 before 00, start code right after
		// the drop, and a trailing start code patched with length zero
		frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h03,
			8'h00, 8'h00, 8'h00, 8'h01};
		send_frame(frame, 1'b0);
		// 03 kept since the next byte is above 3, zeros flushed at frame end
		frame = '{8'h7F, 8'h00, 8'h00, 8'h03, 8'h04, 8'h00};
		send_frame(frame, 1'b0);
		// 03 as the final byte is never dropped
		frame = '{8'h00, 8'h00, 8'h03};
		send_frame(frame, 1'b0);
		// zero run too long, error falls on the final byte
		frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
		send_frame(frame, 1'b0);
		drain();

		// register settings per phase, extremes first, then random
		cfg_epb = '{1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1))};
		cfg_lim = '{3'd2, 3'd7, 3'd2, 3'd7, 3'($urandom_range(2, 7))};
		cfg_flr = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1))};

		for (int p = 0; p < PHASES; p++) begin
			write_config(cfg_epb[p], cfg_lim[p], cfg_flr[p]);
			// second phase: results held back while bytes keep coming
			if (p == 1) begin
				burst_mode = 1'b1;
				hold_req  <= 1'b1;
			end
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				if ($urandom_range(0, 9) == 0) begin
					gen_noise(frame);
					send_frame(frame, 1'b1);
				end else begin
					gen_frame(frame);
					send_frame(frame, 1'b0);
				end
			end
			burst_mode = 1'b0;
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("annexb_to_length_prefixed_nal test passed");
		else
			$display("annexb_to_length_prefixed_nal test failed");
		$finish;
	end

endmodule

### annexb_to_length_prefixed_nal.f
hdl/abnal_pkg.sv
hdl/abnal_front.sv
hdl/abnal_queue.sv
hdl/abnal_back.sv
hdl/annexb_to_length_prefixed_nal.sv
hdl/abnal_checker.sv
bench/abnal_checker.sv
bench/tb_annexb_to_length_prefixed_nal.sv
